// File: rtl/core/cap_pkg.sv
// Shared types and codes for the call arc profiler.
// Used by the memories and the top level.
`default_nettype none
package cap_pkg;

  localparam int STACK_DEPTH_DEF   = 64;
  localparam int TABLE_ENTRIES_DEF = 256;

  // Action codes carried by an input word.
  localparam logic [1:0] ACT_ENTRY  = 2'd0;
  localparam logic [1:0] ACT_EXIT   = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  // The last code has no meaning; such a word is answered with status ok.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_OVERFLOW   = 3'd1;
  localparam logic [2:0] ST_EMPTY      = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_SLOT_EMPTY = 3'd4;

  // One shadow stack frame.
  typedef struct packed {
    logic [63:0] callee;
    logic [63:0] outer_start;
    logic [63:0] inner_start;
  } cap_frame_t;

  // One arc table slot.
  typedef struct packed {
    logic [63:0] callee;
    logic [63:0] parent;
    logic [31:0] count;
    logic [63:0] inner_sum;
    logic [63:0] outer_sum;
  } cap_arc_t;

endpackage
`default_nettype wire

// File: rtl/core/cap_if.sv
// Valid/ready channel interfaces for the profiler input and result words.
// Depends on nothing.
`default_nettype none
interface cap_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [63:0] callee_addr;
  logic [63:0] caller_addr;
  logic [63:0] time_first;
  logic [63:0] time_second;
  logic [7:0]  slot_index;
  modport source (output valid, action, callee_addr, caller_addr, time_first,
                  time_second, slot_index, input ready);
  modport sink (input valid, action, callee_addr, caller_addr, time_first,
                time_second, slot_index, output ready);
endinterface

interface cap_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] entry_callee;
  logic [63:0] entry_parent;
  logic [31:0] call_count;
  logic [63:0] inner_time_sum;
  logic [63:0] outer_time_sum;
  logic [6:0]  max_depth_seen;
  logic [8:0]  slots_used;
  modport source (output valid, status, entry_callee, entry_parent, call_count,
                  inner_time_sum, outer_time_sum, max_depth_seen, slots_used,
                  input ready);
  modport sink (input valid, status, entry_callee, entry_parent, call_count,
                inner_time_sum, outer_time_sum, max_depth_seen, slots_used,
                output ready);
endinterface
`default_nettype wire

// File: rtl/core/cap_stack_mem.sv
// Shadow call stack storage: one write port, one registered read port.
// Depends on cap_pkg for the frame type.
`default_nettype none
module cap_stack_mem
  import cap_pkg::*;
#(
  parameter int DEPTH = STACK_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire cap_frame_t    wdata,
  input  wire logic [AW-1:0] raddr,
  output cap_frame_t         rdata
);

  cap_frame_t mem [DEPTH];

  // Write and read, both synchronous.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/cap_arc_mem.sv
// Arc table storage: one write port, one registered read port.
// Depends on cap_pkg for the slot type.
`default_nettype none
module cap_arc_mem
  import cap_pkg::*;
#(
  parameter int ENTRIES = TABLE_ENTRIES_DEF,
  localparam int AW = $clog2(ENTRIES)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire cap_arc_t      wdata,
  input  wire logic [AW-1:0] raddr,
  output cap_arc_t           rdata
);

  cap_arc_t mem [ENTRIES];

  // Write and read, both synchronous.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/call_arc_profiler.sv
// Call arc profiler top level: sequencer, shadow stack and arc table.
// Depends on cap_pkg, cap_if, cap_stack_mem and cap_arc_mem.
//
//  channel   dir  handshake     word
//  in_ch     in   valid/ready   action, addresses, two times, slot index
//  out_ch    out  valid/ready   status, slot contents, max depth, slots used
//
// An exit also scans the arc table slot by slot through its single read port,
// so its time grows with the number of slots in use; entry, unused and read
// actions do no scan.
// One word is worked on at a time; a new word is taken while the last result
// still waits in the output register. Reset is synchronous and clears the
// stack depth, slot count and max depth; the memories need no clearing.
`default_nettype none
module call_arc_profiler
  import cap_pkg::*;
#(
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  cap_in_if.sink   in_ch,
  cap_out_if.source out_ch
);

  localparam int DW  = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int TW  = $clog2(TABLE_ENTRIES + 1);
  localparam int TAW = $clog2(TABLE_ENTRIES);
  localparam int CW  = (TW > 8) ? TW : 8;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_TOP   = 3'd2;
  localparam logic [2:0] S_BELOW = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_RDW   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [DW-1:0] deepest_r, deepest_nxt;
  logic [TW-1:0] used_r, used_nxt;
  logic [TW-1:0] scan_r, scan_nxt;
  logic [TAW-1:0] pidx_r, pidx_nxt;
  logic          pend_r, pend_nxt;

  logic [1:0]  act_r, act_nxt;
  logic [63:0] callee_r, callee_nxt, caller_r, caller_nxt;
  logic [63:0] t1_r, t1_nxt, t2_r, t2_nxt;
  logic [7:0]  slot_r, slot_nxt;
  logic [63:0] kc_r, kc_nxt, kp_r, kp_nxt;
  logic [63:0] inner_r, inner_nxt, outer_r, outer_nxt;
  logic [2:0]  stat_r, stat_nxt;
  cap_arc_t    res_r, res_nxt;

  logic        ov_r, ov_nxt;
  logic [2:0]  ostat_r, ostat_nxt;
  cap_arc_t    ores_r, ores_nxt;
  logic [6:0]  omax_r, omax_nxt;
  logic [8:0]  oused_r, oused_nxt;

  logic           s_we;
  logic [SAW-1:0] s_waddr, s_raddr;
  cap_frame_t     s_wdata, s_rdata;
  logic           a_we;
  logic [TAW-1:0] a_waddr, a_raddr;
  cap_arc_t       a_wdata, a_rdata;

  logic [CW-1:0] slot_ext, used_ext;
  logic          hit;

  cap_stack_mem #(.DEPTH(STACK_DEPTH)) u_stack (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  cap_arc_mem #(.ENTRIES(TABLE_ENTRIES)) u_arc (
    .clk, .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign slot_ext = CW'(slot_r);
  assign used_ext = CW'(used_r);
  assign hit = pend_r && (a_rdata.callee == kc_r) && (a_rdata.parent == kp_r);

  // Sequencer: one word from acceptance to the output register.
  always_comb begin
    state_nxt = state_r;   depth_nxt = depth_r;   deepest_nxt = deepest_r;
    used_nxt = used_r;     scan_nxt = scan_r;     pidx_nxt = pidx_r;
    pend_nxt = pend_r;     act_nxt = act_r;       callee_nxt = callee_r;
    caller_nxt = caller_r; t1_nxt = t1_r;         t2_nxt = t2_r;
    slot_nxt = slot_r;     kc_nxt = kc_r;         kp_nxt = kp_r;
    inner_nxt = inner_r;   outer_nxt = outer_r;   stat_nxt = stat_r;
    res_nxt = res_r;       ov_nxt = ov_r;         ostat_nxt = ostat_r;
    ores_nxt = ores_r;     omax_nxt = omax_r;     oused_nxt = oused_r;
    s_we = 1'b0;
    s_waddr = depth_r[SAW-1:0];
    s_wdata = '{callee: callee_r, outer_start: t1_r, inner_start: t2_r};
    s_raddr = SAW'(depth_r - DW'(1));
    a_we = 1'b0;
    a_waddr = pidx_r;
    a_wdata = a_rdata;
    a_raddr = scan_r[TAW-1:0];

    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          act_nxt = in_ch.action;       callee_nxt = in_ch.callee_addr;
          caller_nxt = in_ch.caller_addr; t1_nxt = in_ch.time_first;
          t2_nxt = in_ch.time_second;   slot_nxt = in_ch.slot_index;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        res_nxt = '0;
        stat_nxt = ST_OK;
        state_nxt = S_FIN;
        priority if (act_r == ACT_ENTRY) begin
          if (depth_r == DW'(STACK_DEPTH)) begin
            stat_nxt = ST_OVERFLOW;
          end else begin
            s_we = 1'b1;
            depth_nxt = depth_r + DW'(1);
          end
        end else if (act_r == ACT_EXIT) begin
          if (depth_r == '0) begin
            stat_nxt = ST_EMPTY;
          end else begin
            if (depth_r > deepest_r) begin
              deepest_nxt = depth_r;
            end
            state_nxt = S_TOP;
          end
        end else if (act_r == ACT_READ) begin
          a_raddr = slot_ext[TAW-1:0];
          if (slot_ext < used_ext) begin
            state_nxt = S_RDW;
          end else begin
            stat_nxt = ST_SLOT_EMPTY;
          end
        end else begin
          stat_nxt = ST_OK;
        end
      end
      S_TOP: begin
        // Top frame is out: elapsed times and the callee half of the key.
        inner_nxt = t1_r - s_rdata.inner_start;
        outer_nxt = t2_r - s_rdata.outer_start;
        scan_nxt = '0;
        pend_nxt = 1'b0;
        if (depth_r == DW'(1)) begin
          kc_nxt = callee_r;
          kp_nxt = caller_r;
          state_nxt = S_SCAN;
        end else begin
          kc_nxt = s_rdata.callee;
          s_raddr = SAW'(depth_r - DW'(2));
          state_nxt = S_BELOW;
        end
      end
      S_BELOW: begin
        kp_nxt = s_rdata.callee;
        depth_nxt = depth_r - DW'(1);
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // Read one slot per cycle, compare the slot read the cycle before.
        if (hit) begin
          a_we = 1'b1;
          a_waddr = pidx_r;
          a_wdata.count = (a_rdata.count == '1) ? a_rdata.count
                                                : a_rdata.count + 32'd1;
          a_wdata.inner_sum = a_rdata.inner_sum + inner_r;
          a_wdata.outer_sum = a_rdata.outer_sum + outer_r;
          state_nxt = S_FIN;
        end else if (scan_r < used_r) begin
          pend_nxt = 1'b1;
          pidx_nxt = scan_r[TAW-1:0];
          scan_nxt = scan_r + TW'(1);
        end else begin
          state_nxt = S_FIN;
          if (used_r == TW'(TABLE_ENTRIES)) begin
            stat_nxt = ST_FULL;
          end else begin
            a_we = 1'b1;
            a_waddr = used_r[TAW-1:0];
            a_wdata = '{callee: kc_r, parent: kp_r, count: 32'd1,
                        inner_sum: inner_r, outer_sum: outer_r};
            used_nxt = used_r + TW'(1);
          end
        end
      end
      S_RDW: begin
        res_nxt = a_rdata;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          ostat_nxt = stat_r;
          ores_nxt = res_r;
          omax_nxt = 7'(deepest_r);
          oused_nxt = 9'(used_r);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state is reset; payload registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; depth_r <= '0; deepest_r <= '0;
      used_r <= '0;      pend_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; depth_r <= depth_nxt; deepest_r <= deepest_nxt;
      used_r <= used_nxt;   pend_r <= pend_nxt;   ov_r <= ov_nxt;
    end
    scan_r <= scan_nxt;   pidx_r <= pidx_nxt;   act_r <= act_nxt;
    callee_r <= callee_nxt; caller_r <= caller_nxt;
    t1_r <= t1_nxt;       t2_r <= t2_nxt;       slot_r <= slot_nxt;
    kc_r <= kc_nxt;       kp_r <= kp_nxt;
    inner_r <= inner_nxt; outer_r <= outer_nxt; stat_r <= stat_nxt;
    res_r <= res_nxt;     ostat_r <= ostat_nxt; ores_r <= ores_nxt;
    omax_r <= omax_nxt;   oused_r <= oused_nxt;
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.status         = ostat_r;
  assign out_ch.entry_callee   = ores_r.callee;
  assign out_ch.entry_parent   = ores_r.parent;
  assign out_ch.call_count     = ores_r.count;
  assign out_ch.inner_time_sum = ores_r.inner_sum;
  assign out_ch.outer_time_sum = ores_r.outer_sum;
  assign out_ch.max_depth_seen = omax_r;
  assign out_ch.slots_used     = oused_r;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= TW'(TABLE_ENTRIES)) else $error("slot count past table size");
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(STACK_DEPTH)) else $error("stack depth past limit");
  a_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DISP && act_r == ACT_ENTRY && depth_r != DW'(STACK_DEPTH))
    |=> depth_r == $past(depth_r) + DW'(1)) else $error("entry did not push");
  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && hit) |=> state_r == S_FIN)
    else $error("hit did not end scan");
`endif

endmodule
`default_nettype wire
